// File: rtl/track_run_box_parser_unit_defines.svh
// Assertion macros shared by the track-run box parser RTL.
`ifndef TRACK_RUN_BOX_PARSER_UNIT_DEFINES_SVH
`define TRACK_RUN_BOX_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while rst is high.
`define TRBP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and idle while rst is high.
`define TRBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/trbp_pkg.sv
// Types, codes and helpers shared by the track-run box parser modules.
`default_nettype none

package trbp_pkg;

  // Byte counts and the flag group width of the box layout.
  localparam logic [31:0] HEADER_BYTES = 32'd16;
  localparam logic [31:0] WORD_BYTES   = 32'd4;
  localparam int          GROUP_BITS   = 8;

  // Field kinds carried with each result.
  localparam logic [2:0] KIND_COUNT       = 3'd0;
  localparam logic [2:0] KIND_DATA_OFFSET = 3'd1;
  localparam logic [2:0] KIND_FIRST_FLAGS = 3'd2;
  localparam logic [2:0] KIND_DURATION    = 3'd3;
  localparam logic [2:0] KIND_DISCARD     = 3'd7;

  // Parse status codes, reported on the last result of a box.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_EXCEED   = 2'd2;
  localparam logic [1:0] ST_TRUNC    = 2'd3;

  // Parser phase, one-hot.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_OPT  = 3'b010,
    PH_SAMP = 3'b100
  } phase_t;

  // Running state of the open box.
  typedef struct packed {
    phase_t      phase;
    logic [23:0] saved_flags;
    logic [31:0] bytes_remaining;
    logic [31:0] samples_total;
    logic [31:0] sample_index;
    logic [3:0]  record_position;
    logic [3:0]  optional_left;
  } state_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic        valid;
    logic [31:0] sample;
    logic        done;
    logic [1:0]  status;
  } result_t;

  // Number of set bits in one flag group.
  function automatic logic [3:0] popcnt8(input logic [GROUP_BITS-1:0] bits);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < GROUP_BITS; i++) begin
      n = n + {3'b000, bits[i]};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: rtl/trbp_step.sv
// Next-state and result logic for one body word of a track-run box.
`default_nettype none

module trbp_step (
  input  wire trbp_pkg::state_t  cur,
  input  wire logic [31:0]       body_word,
  input  wire logic              box_start,
  input  wire logic [31:0]       box_size,
  input  wire logic [23:0]       box_flags,
  output trbp_pkg::state_t       nxt,
  output trbp_pkg::result_t      res,
  output logic                   has_res
);
  import trbp_pkg::*;

  logic [3:0]  rc_in;
  logic [3:0]  n_in;
  logic [3:0]  rc_sv;
  logic [3:0]  n_sv;
  logic [3:0]  chk_rc;
  logic        hdr_check;
  logic [31:0] total_chk;
  logic [35:0] rec_prod;
  logic [37:0] need_bytes;
  logic [3:0]  pos;
  logic        has_off;
  logic        found;
  logic [3:0]  k;
  logic [3:0]  rp_inc;

  // Record and optional word counts from the incoming and the saved flags.
  assign rc_in = popcnt8(box_flags[15:8]);
  assign n_in  = popcnt8(box_flags[7:0]);
  assign rc_sv = popcnt8(cur.saved_flags[15:8]);
  assign n_sv  = popcnt8(cur.saved_flags[7:0]);

  // Sample count that the table check uses: the start word or the saved count.
  assign total_chk = box_start ? body_word : cur.samples_total;

  // Bytes that the whole sample table needs: record words times 4 times samples.
  assign rec_prod   = 36'(chk_rc) * 36'(total_chk);
  assign need_bytes = {rec_prod, 2'b00};

  always_comb begin
    nxt       = cur;
    res       = '0;
    has_res   = 1'b0;
    hdr_check = 1'b0;
    chk_rc    = rc_sv;
    pos       = '0;
    has_off   = 1'b0;
    found     = 1'b0;
    k         = '0;
    rp_inc    = '0;

    if (box_start) begin
      // A start word opens a box and abandons any box still open.
      has_res                = 1'b1;
      nxt.saved_flags        = box_flags;
      nxt.sample_index       = '0;
      nxt.record_position    = '0;
      res.kind               = KIND_COUNT;
      if (box_size < HEADER_BYTES) begin
        nxt.phase           = PH_IDLE;
        nxt.bytes_remaining = '0;
        nxt.samples_total   = '0;
        nxt.optional_left   = '0;
        res.done            = 1'b1;
        res.status          = ST_SHORT;
      end else begin
        nxt.phase           = PH_OPT;
        nxt.bytes_remaining = box_size - HEADER_BYTES;
        nxt.samples_total   = body_word;
        nxt.optional_left   = n_in;
        res.value           = body_word;
        res.valid           = 1'b1;
        hdr_check           = 1'b1;
        chk_rc              = rc_in;
      end
    end else begin
      unique case (cur.phase)
        PH_OPT: begin
          // Optional words: data offset first, then first-sample flags, rest unknown.
          pos     = n_sv - cur.optional_left;
          has_off = cur.saved_flags[0];
          if (has_off && pos == 4'd0) begin
            res.kind = KIND_DATA_OFFSET;
          end else if (cur.saved_flags[2] && pos == {3'b000, has_off}) begin
            res.kind = KIND_FIRST_FLAGS;
          end else begin
            res.kind = KIND_DISCARD;
          end
          res.value           = body_word;
          res.valid           = (res.kind != KIND_DISCARD);
          has_res             = 1'b1;
          nxt.bytes_remaining = cur.bytes_remaining - WORD_BYTES;
          nxt.optional_left   = cur.optional_left - 4'd1;
          hdr_check           = 1'b1;
        end
        PH_SAMP: begin
          // Find which present per-sample field sits at this record position.
          res.kind = KIND_DISCARD;
          for (int b = 0; b < 4; b++) begin
            if (!found && cur.saved_flags[GROUP_BITS+b]) begin
              if (k == cur.record_position) begin
                found    = 1'b1;
                res.kind = KIND_DURATION + 3'(b);
              end
              k = k + 4'd1;
            end
          end
          res.value           = body_word;
          res.valid           = found;
          res.sample          = cur.sample_index;
          has_res             = 1'b1;
          nxt.bytes_remaining = cur.bytes_remaining - WORD_BYTES;
          rp_inc              = cur.record_position + 4'd1;
          if (rp_inc >= rc_sv) begin
            nxt.record_position = '0;
            nxt.sample_index    = cur.sample_index + 32'd1;
          end else begin
            nxt.record_position = rp_inc;
          end
          // Close after the last sample, or when words run out early.
          if (nxt.sample_index == cur.samples_total) begin
            nxt.phase  = PH_IDLE;
            res.done   = 1'b1;
            res.status = ST_OK;
          end else if (nxt.bytes_remaining < WORD_BYTES) begin
            nxt.phase  = PH_IDLE;
            res.done   = 1'b1;
            res.status = ST_TRUNC;
          end
        end
        PH_IDLE: begin
          // A stray word outside a box gives no result.
        end
        default: begin
        end
      endcase
    end

    // Decide what follows a header-area word: more optional words or the sample table.
    if (hdr_check) begin
      if (nxt.optional_left != 4'd0) begin
        if (nxt.bytes_remaining < WORD_BYTES) begin
          nxt.phase  = PH_IDLE;
          res.done   = 1'b1;
          res.status = ST_TRUNC;
        end
      end else if (chk_rc == 4'd0 || nxt.samples_total == 32'd0) begin
        nxt.phase  = PH_IDLE;
        res.done   = 1'b1;
        res.status = ST_OK;
      end else if ({6'b000000, nxt.bytes_remaining} < need_bytes) begin
        nxt.phase  = PH_IDLE;
        res.done   = 1'b1;
        res.status = ST_EXCEED;
      end else begin
        nxt.phase           = PH_SAMP;
        nxt.sample_index    = '0;
        nxt.record_position = '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/track_run_box_parser_unit.sv
// Top level of the track-run box parser: input register, step logic, result register.
//
//   Channel | Signals                                  | Carries
//   s_*     | s_tvalid s_tready s_tdata[87:0] s_tuser  | body words with box size and flags
//   m_*     | m_tvalid m_tready m_tdata[71:0] m_tuser  | decoded fields and box status
//
// One word is taken per cycle unless a held result stalls; results are registered.
// The input register feeds the step logic, which updates the box state and the result
// register in the same cycle, so the state loop through that logic sets the rate.
// Reset clears both valid flags and the box state; the parser then waits for a start word.
// While m_tready is low the result holds and one further word waits in the input register.
`default_nettype none

module track_run_box_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [87:0] s_tdata,   // body_word[31:0], box_size[63:32], box_flags[87:64]
  input  wire logic        s_tuser,   // box_start[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // field_value[31:0], sample_number[63:32],
                                      // parse_status[65:64], zero fill[71:66]
  output logic [3:0]       m_tuser,   // field_kind[2:0], field_valid[3]
  output logic             m_tlast    // box_done
);
  import trbp_pkg::*;

  `include "track_run_box_parser_unit_defines.svh"

  logic        in_valid;
  logic [31:0] in_word;
  logic        in_start;
  logic [31:0] in_size;
  logic [23:0] in_flags;
  state_t      state;
  state_t      state_next;
  result_t     step_res;
  logic        step_has_res;
  logic        step_fire;
  result_t     out_res;
  logic        out_valid;
  logic        out_bad_status;
  logic        close_fire;
  logic [3:0]  rec_words;
  logic        rec_in_range;
  logic        in_samp;
  logic        in_opt;
  logic        opt_pending;

  // A held word moves on once the result register is free or being emptied.
  assign step_fire = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || step_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_word  <= s_tdata[31:0];
      in_size  <= s_tdata[63:32];
      in_flags <= s_tdata[87:64];
      in_start <= s_tuser;
    end
  end

  trbp_step u_step (
    .cur       (state),
    .body_word (in_word),
    .box_start (in_start),
    .box_size  (in_size),
    .box_flags (in_flags),
    .nxt       (state_next),
    .res       (step_res),
    .has_res   (step_has_res)
  );

  // Box state advances with each word that leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase           <= PH_IDLE;
      state.saved_flags     <= '0;
      state.bytes_remaining <= '0;
      state.samples_total   <= '0;
      state.sample_index    <= '0;
      state.record_position <= '0;
      state.optional_left   <= '0;
    end else if (step_fire) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire) begin
      out_valid <= step_has_res;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && step_has_res) begin
      out_res <= step_res;
    end
  end

  // Pack the result onto the master side.
  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b000000, out_res.status, out_res.sample, out_res.value};
  assign m_tuser  = {out_res.valid, out_res.kind};
  assign m_tlast  = out_res.done;

  // Conditions that the checks below watch.
  assign out_bad_status = m_tvalid && (out_res.status != ST_OK);
  assign close_fire     = step_fire && step_has_res && step_res.done;
  assign rec_words      = popcnt8(state.saved_flags[15:8]);
  assign rec_in_range   = state.record_position < rec_words;
  assign in_samp        = (state.phase == PH_SAMP);
  assign in_opt         = (state.phase == PH_OPT);
  assign opt_pending    = (state.optional_left != 4'd0);

  // A failing status only ever closes a box.
  `TRBP_ASSERT_IMPL(a_status_on_done, out_bad_status, m_tlast, "status without box_done")
  // After the closing result is computed the parser is idle.
  `TRBP_ASSERT_NEXT(a_idle_after_done, close_fire, state.phase == PH_IDLE, "box open after done")
  // Within the sample table the record position stays below the record length.
  `TRBP_ASSERT_IMPL(a_record_bound, in_samp, rec_in_range, "record position overflow")
  // The optional phase is only held while optional words remain.
  `TRBP_ASSERT_IMPL(a_optional_left, in_opt, opt_pending, "optional phase with no words left")

endmodule

`default_nettype wire

// File: verif/tb_track_run_box_parser_unit.sv
// Self-checking testbench for the track-run box parser: stimulus, prediction and result checks.
`default_nettype none

module tb_track_run_box_parser_unit;
  import trbp_pkg::*;

  // One body word as offered on the input stream.
  typedef struct packed {
    logic [31:0] word;
    logic        start;
    logic [31:0] size;
    logic [23:0] flags;
  } trun_word_t;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata  = '0;   // body_word[31:0], box_size[63:32], box_flags[87:64]
  logic        s_tuser  = 1'b0; // box_start[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;         // field_value[31:0], sample_number[63:32],
                                // parse_status[65:64], zero fill[71:66]
  logic [3:0]  m_tuser;         // field_kind[2:0], field_valid[3]
  logic        m_tlast;         // box_done

  track_run_box_parser_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Words waiting to be offered and decoded fields still to arrive.
  trun_word_t words_pending[$];
  result_t    fields_expected[$];

  // Predicted parser state.
  phase_t      run_phase;
  logic [23:0] run_flags;
  logic [31:0] run_bytes;
  logic [31:0] samples_total;
  logic [31:0] sample_idx;
  logic [3:0]  rec_pos;
  logic [3:0]  opt_left;

  int errors;
  int n_words;
  int n_boxes;
  int n_fields;
  int status_seen[4];

  trun_word_t cur_word;
  result_t    pred_field;
  result_t    got_field;
  result_t    want_field;

  int       burst_left;
  int       gap_left;
  int       hold_left;
  bit       hold_done;
  int       mode_left;
  rx_mode_t rx_mode;
  logic     rx_next;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset held at the start of the run only.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Decides what follows a consumed word and marks the end of the box.
  function automatic void close_check(inout result_t r);
    logic [3:0] rec_words;
    rec_words = 4'($countones(run_flags[15:8]));
    if (run_phase != PH_SAMP) begin
      if (opt_left > 0) begin
        if (run_bytes < WORD_BYTES) begin
          run_phase = PH_IDLE;
          r.done    = 1'b1;
          r.status  = ST_TRUNC;
        end else begin
          run_phase = PH_OPT;
        end
      end else if (rec_words == 0 || samples_total == 0) begin
        run_phase = PH_IDLE;
        r.done    = 1'b1;
        r.status  = ST_OK;
      end else if (run_bytes / ({28'd0, rec_words} * WORD_BYTES) < samples_total) begin
        run_phase = PH_IDLE;
        r.done    = 1'b1;
        r.status  = ST_EXCEED;
      end else begin
        run_phase  = PH_SAMP;
        sample_idx = '0;
        rec_pos    = '0;
      end
    end else if (sample_idx == samples_total) begin
      run_phase = PH_IDLE;
      r.done    = 1'b1;
      r.status  = ST_OK;
    end else if (run_bytes < WORD_BYTES) begin
      run_phase = PH_IDLE;
      r.done    = 1'b1;
      r.status  = ST_TRUNC;
    end
  endfunction

  // Decodes one accepted word; returns 1 when it yields a field.
  function automatic bit trun_predict(input trun_word_t w, output result_t r);
    logic [3:0] rec_words;
    logic [3:0] opt_total;
    logic [3:0] pos;
    logic [3:0] known;
    logic [2:0] kind;
    logic       has_off;
    logic       found;
    r = '0;
    if (w.start) begin
      run_flags  = w.flags;
      sample_idx = '0;
      rec_pos    = '0;
      if (w.size < HEADER_BYTES) begin
        run_phase     = PH_IDLE;
        run_bytes     = '0;
        samples_total = '0;
        opt_left      = '0;
        r.kind        = KIND_COUNT;
        r.done        = 1'b1;
        r.status      = ST_SHORT;
        return 1'b1;
      end
      run_bytes     = w.size - HEADER_BYTES;
      samples_total = w.word;
      opt_left      = 4'($countones(w.flags[7:0]));
      run_phase     = PH_OPT;
      r.kind        = KIND_COUNT;
      r.value       = w.word;
      r.valid       = 1'b1;
      close_check(r);
      return 1'b1;
    end

    // Optional words: data offset, first-sample flags, then unknown words.
    if (run_phase == PH_OPT) begin
      opt_total = 4'($countones(run_flags[7:0]));
      pos       = opt_total - opt_left;
      has_off   = run_flags[0];
      kind      = KIND_DISCARD;
      if (has_off && pos == 0) begin
        kind = KIND_DATA_OFFSET;
      end else if (run_flags[2] && pos == {3'b000, has_off}) begin
        kind = KIND_FIRST_FLAGS;
      end
      run_bytes = run_bytes - WORD_BYTES;
      opt_left  = opt_left - 4'd1;
      r.kind    = kind;
      r.value   = w.word;
      r.valid   = (kind != KIND_DISCARD);
      close_check(r);
      return 1'b1;
    end

    // Sample records: known fields in flag order, then unknown words.
    if (run_phase == PH_SAMP) begin
      rec_words = 4'($countones(run_flags[15:8]));
      kind      = KIND_DISCARD;
      known     = '0;
      found     = 1'b0;
      for (int b = 0; b < 4; b++) begin
        if (run_flags[8 + b] && !found) begin
          if (known == rec_pos) begin
            kind  = KIND_DURATION + 3'(b);
            found = 1'b1;
          end else begin
            known = known + 4'd1;
          end
        end
      end
      r.kind    = kind;
      r.value   = w.word;
      r.valid   = (kind != KIND_DISCARD);
      r.sample  = sample_idx;
      run_bytes = run_bytes - WORD_BYTES;
      rec_pos   = rec_pos + 4'd1;
      if (rec_pos >= rec_words) begin
        rec_pos    = '0;
        sample_idx = sample_idx + 32'd1;
      end
      close_check(r);
      return 1'b1;
    end

    // A continuation word while idle is dropped.
    return 1'b0;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_word(input logic [31:0] word, input logic start,
                          input logic [31:0] size, input logic [23:0] flags);
    trun_word_t w;
    w.word  = word;
    w.start = start;
    w.size  = size;
    w.flags = flags;
    words_pending.push_back(w);
    n_words++;
  endtask

  // A start word carrying the sample count, followed by body words.
  task automatic add_box(input logic [23:0] flags, input logic [31:0] count,
                         input logic [31:0] size, input int n_body);
    add_word(count, 1'b1, size, flags);
    for (int i = 0; i < n_body; i++) begin
      add_word(rand_word(), 1'b0, $urandom, 24'($urandom));
    end
    n_boxes++;
  endtask

  // Mostly well-formed boxes, the rest cut short, oversized or abandoned.
  task automatic add_random_box();
    logic [23:0] flags;
    logic [31:0] count;
    logic [31:0] size;
    int          opt;
    int          rec;
    int          n_body;
    int          sel;
    flags  = 24'($urandom);
    opt    = $countones(flags[7:0]);
    rec    = $countones(flags[15:8]);
    count  = $urandom_range(0, 4);
    n_body = opt + rec * count;
    size   = 16 + 4 * n_body;
    sel    = $urandom_range(0, 99);
    if (sel < 65) begin
      if ($urandom_range(0, 3) == 0) size = size + $urandom_range(1, 7);
      if ($urandom_range(0, 7) == 0) n_body = n_body + 1;
    end else if (sel < 75) begin
      if (opt > 0) size = 16 + $urandom_range(0, 4 * opt - 1);
    end else if (sel < 83) begin
      if (rec > 0 && count > 0) size = 16 + 4 * opt + $urandom_range(0, 4 * rec * count - 1);
    end else if (sel < 88) begin
      size   = $urandom_range(0, 15);
      n_body = $urandom_range(0, 2);
    end else if (sel < 96) begin
      n_body = $urandom_range(0, n_body);
    end else begin
      size   = $urandom;
      count  = $urandom;
      n_body = $urandom_range(0, 8);
    end
    add_box(flags, count, size, n_body);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // Sender: bursts of transfers with random gaps, fed from the pending queue.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      run_phase  = PH_IDLE;
      run_flags  = '0;
      run_bytes  = '0;
      samples_total = '0;
      sample_idx = '0;
      rec_pos    = '0;
      opt_left   = '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (trun_predict(cur_word, pred_field)) fields_expected.push_back(pred_field);
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (words_pending.size() > 0) begin
          cur_word = words_pending.pop_front();
          s_tdata  <= {cur_word.flags, cur_word.size, cur_word.word};
          s_tuser  <= cur_word.start;
          s_tvalid <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each transfer and stalls on its own pattern.
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      mode_left = 0;
      rx_mode   = RX_FREE;
    end else begin
      if (m_tvalid && m_tready) begin
        got_field.kind   = m_tuser[2:0];
        got_field.valid  = m_tuser[3];
        got_field.value  = m_tdata[31:0];
        got_field.sample = m_tdata[63:32];
        got_field.status = m_tdata[65:64];
        got_field.done   = m_tlast;
        if (fields_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got kind %0d value 0x%0h",
                   $time, got_field.kind, got_field.value);
        end else begin
          want_field = fields_expected.pop_front();
          n_fields++;
          if (want_field.done) status_seen[want_field.status]++;
          if (got_field.kind != want_field.kind)
            report_mismatch("field_kind", 32'(want_field.kind), 32'(got_field.kind));
          if (got_field.value != want_field.value)
            report_mismatch("field_value", want_field.value, got_field.value);
          if (got_field.valid != want_field.valid)
            report_mismatch("field_valid", 32'(want_field.valid), 32'(got_field.valid));
          if (got_field.sample != want_field.sample)
            report_mismatch("sample_number", want_field.sample, got_field.sample);
          if (got_field.done != want_field.done)
            report_mismatch("box_done", 32'(want_field.done), 32'(got_field.done));
          if (got_field.status != want_field.status)
            report_mismatch("parse_status", 32'(want_field.status), 32'(got_field.status));
        end
      end

      // One long hold-off while the sender still has plenty to offer.
      if (hold_left > 0) begin
        hold_left--;
        rx_next = 1'b0;
      end else if (!hold_done && n_fields >= 300 && words_pending.size() > 100) begin
        hold_done = 1'b1;
        hold_left = 300;
        rx_next   = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 80);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_FREE:  rx_next = 1'b1;
          RX_LIGHT: rx_next = ($urandom_range(0, 3) != 0);
          RX_HEAVY: rx_next = ($urandom_range(0, 3) == 0);
          default:  rx_next = !m_tready;
        endcase
      end
      m_tready <= rx_next;
    end
  end

  // Stimulus and end of run.
  initial begin
    int target;
    errors   = 0;
    n_words  = 0;
    n_boxes  = 0;
    n_fields = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;

    // Directed: stray word, short boxes, every field kind, unknown record
    // words with an abandoned box, truncation, zero samples, sample overflow.
    add_word('1, 1'b0, '1, '1);
    add_box(24'hFFFFFF, 32'd0, 32'd0, 0);
    add_box(24'h000000, '1, 32'd15, 0);
    add_box(24'h000000, 32'd0, 32'd16, 0);
    add_box(24'h000F05, 32'd1, 32'd40, 6);
    add_box(24'h00F204, 32'd1, 32'd40, 3);
    add_box(24'hFFFFFF, 32'd0, 32'd28, 3);
    add_box(24'h000300, 32'd0, 32'd100, 0);
    add_box(24'h000100, '1, '1, 0);

    // Random boxes in chunks; the sender waits for every result between them.
    for (int chunk = 0; chunk < 3; chunk++) begin
      while (words_pending.size() > 0 || s_tvalid || fields_expected.size() > 0)
        @(negedge clk);
      target = n_words + 350;
      while (n_words < target) add_random_box();
    end

    while (words_pending.size() > 0 || s_tvalid) @(negedge clk);
    for (int i = 0; i < 4000 && fields_expected.size() > 0; i++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fields_expected.size() > 0) begin
      errors++;
      $display("%0t: %0d results never arrived, expected kind %0d value 0x%0h",
               $time, fields_expected.size(), fields_expected[0].kind,
               fields_expected[0].value);
    end

    $display("Sent %0d words in %0d boxes, %0d results checked.", n_words, n_boxes, n_fields);
    $display("Boxes closed: %0d ok, %0d too short, %0d over size, %0d truncated.",
             status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_EXCEED],
             status_seen[ST_TRUNC]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/trbp_pkg.sv
rtl/trbp_step.sv
rtl/track_run_box_parser_unit.sv
verif/tb_track_run_box_parser_unit.sv
